/* rtl/rotary_encoder_calibration_tracker_unit_assert.svh */
// Assertion macros for the checker file of the tracker.
// No dependencies; expects aclk and aresetn in the scope of each use.
`ifndef ROTARY_ENCODER_CALIBRATION_TRACKER_UNIT_ASSERT_SVH
`define ROTARY_ENCODER_CALIBRATION_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RECT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RECT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rect_pkg.sv */
// Shared types and constants of the rotary encoder calibration tracker.
// No dependencies.
`timescale 1ns / 1ps

package rect_pkg;

    // Stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 200;
    localparam int M_PAD_W   = 3;

    // Result kinds (m_tuser)
    localparam logic [1:0] EV_POINT = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_DONE  = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_WIN_SEGS    = 1'b0;
    localparam logic REG_DEBOUNCE_MS = 1'b1;

    // Register reset values
    localparam logic [4:0]  WIN_SEGS_RESET = 5'd5;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd250;

    // Legal window count range
    localparam logic [4:0] WC_MIN = 5'd1;
    localparam logic [4:0] WC_MAX = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_BOUND,
        ST_WIN_GO,
        ST_WIN,
        ST_EMIT_PT,
        ST_PRESS,
        ST_EMIT_BTN
    } rect_state_t;

    typedef enum logic [1:0] {
        WIN_IDLE,
        WIN_SEG,
        WIN_IDX
    } win_phase_t;

    // Sequencer to tracker commands
    typedef struct packed {
        logic load;
        logic step;
        logic bound;
        logic press;
    } trk_cmd_t;

    // Tracker status back to the sequencer
    typedef struct packed {
        logic point;
        logic press;
        logic capturing;
    } trk_stat_t;

    // Window unit result
    typedef struct packed {
        logic       done;
        logic [3:0] window;
    } win_stat_t;

endpackage

/* rtl/rect_track.sv */
// Encoder count, overall and session bounds, button debounce and capture state.
// Depends on rect_pkg.
`timescale 1ns / 1ps

module rect_track #(
    parameter int COUNT_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rect_pkg::trk_cmd_t            cmd,
    input  logic                          clk_level,
    input  logic                          dt_level,
    input  logic                          button_level,
    input  logic [31:0]                   now_ms,
    input  logic [15:0]                   debounce_ms,
    output rect_pkg::trk_stat_t           stat,
    output logic signed [COUNT_BITS-1:0]  count_value,
    output logic signed [COUNT_BITS-1:0]  overall_low,
    output logic signed [COUNT_BITS-1:0]  overall_high,
    output logic signed [COUNT_BITS-1:0]  start_count,
    output logic signed [COUNT_BITS-1:0]  capture_low,
    output logic signed [COUNT_BITS-1:0]  capture_high
);

    localparam logic signed [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic signed [COUNT_BITS-1:0] ONE  = COUNT_BITS'(1);

    // sample latched at accept
    logic        clk_s_reg, dt_s_reg, btn_s_reg;
    logic [31:0] now_s_reg;

    logic signed [COUNT_BITS-1:0] count_reg, count_next;
    logic signed [COUNT_BITS-1:0] low_reg, low_next;
    logic signed [COUNT_BITS-1:0] high_reg, high_next;
    logic signed [COUNT_BITS-1:0] start_reg, start_next;
    logic signed [COUNT_BITS-1:0] cap_low_reg, cap_low_next;
    logic signed [COUNT_BITS-1:0] cap_high_reg, cap_high_next;
    logic        last_clk_reg, last_clk_next;
    logic        last_btn_reg, last_btn_next;
    logic [31:0] last_press_reg, last_press_next;
    logic        capturing_reg, capturing_next;
    logic        point_reg, point_next;
    logic        press_reg, press_next;

    logic        fall;
    logic        up;
    logic        moves;
    logic [31:0] elapsed;

    always_comb begin
        count_next      = count_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        start_next      = start_reg;
        cap_low_next    = cap_low_reg;
        cap_high_next   = cap_high_reg;
        last_clk_next   = last_clk_reg;
        last_btn_next   = last_btn_reg;
        last_press_next = last_press_reg;
        capturing_next  = capturing_reg;
        point_next      = point_reg;
        press_next      = press_reg;

        fall    = last_clk_reg & ~clk_s_reg;
        up      = dt_s_reg != clk_s_reg;
        moves   = up ? (count_reg != CMAX) : (count_reg != CMIN);
        elapsed = now_s_reg - last_press_reg;

        if (cmd.step) begin
            if (fall && moves) begin
                count_next = up ? count_reg + ONE : count_reg - ONE;
            end
            point_next    = fall & moves;
            last_clk_next = clk_s_reg;
            press_next    = last_btn_reg & ~btn_s_reg & (elapsed >= {16'd0, debounce_ms});
            last_btn_next = btn_s_reg;
        end

        if (cmd.bound) begin
            if (count_reg < low_reg) begin
                low_next = count_reg;
            end
            if (count_reg > high_reg) begin
                high_next = count_reg;
            end
            if (point_reg && capturing_reg) begin
                if (count_reg < cap_low_reg) begin
                    cap_low_next = count_reg;
                end
                if (count_reg > cap_high_reg) begin
                    cap_high_next = count_reg;
                end
            end
        end

        if (cmd.press && press_reg) begin
            last_press_next = now_s_reg;
            if (capturing_reg) begin
                capturing_next = 1'b0;
            end else begin
                capturing_next = 1'b1;
                start_next     = count_reg;
                cap_low_next   = count_reg;
                cap_high_next  = count_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            clk_s_reg <= clk_level;
            dt_s_reg  <= dt_level;
            btn_s_reg <= button_level;
            now_s_reg <= now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            low_reg        <= '0;
            high_reg       <= '0;
            start_reg      <= '0;
            cap_low_reg    <= '0;
            cap_high_reg   <= '0;
            last_clk_reg   <= 1'b1;
            last_btn_reg   <= 1'b1;
            last_press_reg <= '0;
            capturing_reg  <= 1'b0;
            point_reg      <= 1'b0;
            press_reg      <= 1'b0;
        end else begin
            count_reg      <= count_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            start_reg      <= start_next;
            cap_low_reg    <= cap_low_next;
            cap_high_reg   <= cap_high_next;
            last_clk_reg   <= last_clk_next;
            last_btn_reg   <= last_btn_next;
            last_press_reg <= last_press_next;
            capturing_reg  <= capturing_next;
            point_reg      <= point_next;
            press_reg      <= press_next;
        end
    end

    assign stat.point     = point_reg;
    assign stat.press     = press_reg;
    assign stat.capturing = capturing_reg;
    assign count_value    = count_reg;
    assign overall_low    = low_reg;
    assign overall_high   = high_reg;
    assign start_count    = start_reg;
    assign capture_low    = cap_low_reg;
    assign capture_high   = cap_high_reg;

endmodule

/* rtl/rect_win_div.sv */
// Window index unit: bit-serial span / window count, then a five-step
// restoring divide of (count - low) by the segment. Depends on rect_pkg.
`timescale 1ns / 1ps

module rect_win_div #(
    parameter int COUNT_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [4:0]                    win_segs,
    input  logic signed [COUNT_BITS-1:0]  count_value,
    input  logic signed [COUNT_BITS-1:0]  overall_low,
    input  logic signed [COUNT_BITS-1:0]  overall_high,
    output rect_pkg::win_stat_t           stat
);

    localparam int CNT_W = $clog2(COUNT_BITS);

    rect_pkg::win_phase_t phase_reg, phase_next;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] sh_reg, sh_next;     // span in, segment out
    logic [3:0]            rem_reg, rem_next;
    logic [COUNT_BITS-1:0] num_reg, num_next;   // count - low, reduced in place
    logic [3:0]            q_reg, q_next;
    logic                  done_reg, done_next;
    logic [3:0]            win_reg, win_next;

    logic [4:0]              wce;
    logic [4:0]              wce_m1;
    logic [4:0]              trial;
    logic                    ge_seg;
    logic [COUNT_BITS+3:0]   dsh;
    logic                    ge_idx;
    logic [4:0]              q_fin;

    always_comb begin
        if (win_segs < rect_pkg::WC_MIN) begin
            wce = rect_pkg::WC_MIN;
        end else if (win_segs > rect_pkg::WC_MAX) begin
            wce = rect_pkg::WC_MAX;
        end else begin
            wce = win_segs;
        end
        wce_m1 = wce - 5'd1;

        trial  = {rem_reg, sh_reg[COUNT_BITS-1]};
        ge_seg = trial >= wce;

        dsh    = {4'd0, sh_reg} << cnt_reg[2:0];
        ge_idx = {4'd0, num_reg} >= dsh;
        q_fin  = {q_reg, ge_idx};

        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        win_next   = win_reg;

        case (phase_reg)
            rect_pkg::WIN_IDLE: begin
                if (start) begin
                    sh_next    = overall_high - overall_low;
                    num_next   = count_value - overall_low;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(COUNT_BITS - 1);
                    phase_next = rect_pkg::WIN_SEG;
                end
            end
            rect_pkg::WIN_SEG: begin
                rem_next = ge_seg ? 4'(trial - wce) : trial[3:0];
                sh_next  = {sh_reg[COUNT_BITS-2:0], ge_seg};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    cnt_next   = CNT_W'(4);
                    q_next     = '0;
                    phase_next = rect_pkg::WIN_IDX;
                end
            end
            rect_pkg::WIN_IDX: begin
                if (ge_idx) begin
                    num_next = num_reg - dsh[COUNT_BITS-1:0];
                end
                q_next   = q_fin[3:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    // a zero segment means the span is below the window count
                    if (sh_reg == '0) begin
                        win_next = '0;
                    end else if (q_fin > wce_m1) begin
                        win_next = wce_m1[3:0];
                    end else begin
                        win_next = q_fin[3:0];
                    end
                    done_next  = 1'b1;
                    phase_next = rect_pkg::WIN_IDLE;
                end
            end
            default: begin
                phase_next = rect_pkg::WIN_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rect_pkg::WIN_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        num_reg <= num_next;
        q_reg   <= q_next;
        win_reg <= win_next;
    end

    assign stat.done   = done_reg;
    assign stat.window = win_reg;

endmodule

/* rtl/rotary_encoder_calibration_tracker_unit.sv */
// Top level of the rotary encoder calibration tracker.
// Depends on rect_pkg, rect_track and rect_win_div.
//
// Input stream (s_*): one beat per pin sample. s_tdata from bit 0 up:
// clk_level, dt_level, button_level, now_ms[31:0], zero pad to 40 bits.
// Result stream (m_*): zero, one or two beats per sample. m_tuser is the
// result kind (point, capture start, capture done); m_tlast marks the final
// beat caused by a sample. A sample that moves neither the count nor the
// capture state produces no beat at all.
// Config: APB registers, number of windows at 0x0 and debounce_ms at 0x4.
// The user must write them only while the block is idle; the block itself
// does not enforce this. Reads return the stored values.
// Sequence: one sample at a time: step, bound update, bit-serial span /
// window count, then index division. A point beat comes before a start or
// done beat of the same sample. s_tready returns once the last beat is
// registered; a sample with no result frees it after the bound update.
// The output register lets the next sample be accepted while the final beat
// waits. A stalled receiver holds the beat; a second beat waits for it.
// Reset (aresetn low, synchronous): count, bounds, session values and press
// time go to zero, pin history to released/high, capture off, registers to
// their defaults, no beat pending.
`timescale 1ns / 1ps

module rotary_encoder_calibration_tracker_unit #(
    parameter int COUNT_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input samples
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // clk_level, dt_level, button_level, now_ms[31:0], pad
    input  logic [rect_pkg::S_TDATA_W-1:0] s_tdata,
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // position[31:0], delta[32:0], window[3:0], session_start[31:0],
    // session_low[31:0], session_high[31:0], session_span[31:0], pad
    output logic [rect_pkg::M_TDATA_W-1:0] m_tdata,
    // event_kind[1:0]
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    // ---------------- configuration registers ----------------
    logic [4:0]  wc_reg;
    logic [15:0] deb_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg  <= rect_pkg::WIN_SEGS_RESET;
            deb_reg <= rect_pkg::DEBOUNCE_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                rect_pkg::REG_WIN_SEGS:    wc_reg  <= pwdata[4:0];
                rect_pkg::REG_DEBOUNCE_MS: deb_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rect_pkg::REG_WIN_SEGS:    prdata = {27'd0, wc_reg};
            rect_pkg::REG_DEBOUNCE_MS: prdata = {16'd0, deb_reg};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- datapath units ----------------
    rect_pkg::trk_cmd_t  trk_cmd;
    rect_pkg::trk_stat_t trk_stat;
    rect_pkg::win_stat_t win_stat;
    logic                win_start;

    logic signed [COUNT_BITS-1:0] count_value, overall_low, overall_high;
    logic signed [COUNT_BITS-1:0] start_count, capture_low, capture_high;

    rect_track #(
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (trk_cmd),
        .clk_level    (s_tdata[0]),
        .dt_level     (s_tdata[1]),
        .button_level (s_tdata[2]),
        .now_ms       (s_tdata[34:3]),
        .debounce_ms  (deb_reg),
        .stat         (trk_stat),
        .count_value  (count_value),
        .overall_low  (overall_low),
        .overall_high (overall_high),
        .start_count  (start_count),
        .capture_low  (capture_low),
        .capture_high (capture_high)
    );

    rect_win_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_win (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (win_start),
        .win_segs     (wc_reg),
        .count_value  (count_value),
        .overall_low  (overall_low),
        .overall_high (overall_high),
        .stat         (win_stat)
    );

    // ---------------- beat formatting ----------------
    // Wider counts keep their low bits; narrower ones are sign extended, but the span is zero extended.
    logic signed [COUNT_BITS:0]   delta_w;
    logic [COUNT_BITS-1:0]        span_w;
    logic [rect_pkg::M_TDATA_W-1:0] beat_data;
    logic [1:0]                   beat_kind;
    logic                         beat_last;
    logic                         beat_load;

    assign delta_w = {count_value[COUNT_BITS-1], count_value}
                   - {start_count[COUNT_BITS-1], start_count};
    assign span_w  = capture_high - capture_low;

    always_comb begin
        beat_data = {
            {rect_pkg::M_PAD_W{1'b0}},
            (beat_kind == rect_pkg::EV_DONE) ? 32'(span_w) : 32'd0,
            32'(capture_high),
            32'(capture_low),
            32'(start_count),
            win_stat.window,
            33'(delta_w),
            32'(count_value)
        };
    end

    // ---------------- sequencer ----------------
    rect_pkg::rect_state_t state_reg, state_next;

    logic out_free;
    assign out_free = ~m_tvalid | m_tready;

    always_comb begin
        state_next = state_reg;
        trk_cmd    = '0;
        win_start  = 1'b0;
        s_tready   = 1'b0;
        beat_load  = 1'b0;
        beat_kind  = rect_pkg::EV_POINT;
        beat_last  = 1'b0;

        case (state_reg)
            rect_pkg::ST_IDLE: begin
                s_tready     = 1'b1;
                trk_cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = rect_pkg::ST_STEP;
                end
            end
            rect_pkg::ST_STEP: begin
                trk_cmd.step = 1'b1;
                state_next   = rect_pkg::ST_BOUND;
            end
            rect_pkg::ST_BOUND: begin
                trk_cmd.bound = 1'b1;
                state_next = (trk_stat.point | trk_stat.press) ? rect_pkg::ST_WIN_GO
                                                               : rect_pkg::ST_IDLE;
            end
            rect_pkg::ST_WIN_GO: begin
                win_start  = 1'b1;
                state_next = rect_pkg::ST_WIN;
            end
            rect_pkg::ST_WIN: begin
                if (win_stat.done) begin
                    state_next = trk_stat.point ? rect_pkg::ST_EMIT_PT : rect_pkg::ST_PRESS;
                end
            end
            rect_pkg::ST_EMIT_PT: begin
                beat_kind = rect_pkg::EV_POINT;
                beat_last = ~trk_stat.press;
                if (out_free) begin
                    beat_load  = 1'b1;
                    state_next = trk_stat.press ? rect_pkg::ST_PRESS : rect_pkg::ST_IDLE;
                end
            end
            rect_pkg::ST_PRESS: begin
                trk_cmd.press = 1'b1;
                state_next    = rect_pkg::ST_EMIT_BTN;
            end
            rect_pkg::ST_EMIT_BTN: begin
                // capture flag has already toggled
                beat_kind = trk_stat.capturing ? rect_pkg::EV_START : rect_pkg::EV_DONE;
                beat_last = 1'b1;
                if (out_free) begin
                    beat_load  = 1'b1;
                    state_next = rect_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rect_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rect_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- output register ----------------
    logic                           m_tvalid_reg;
    logic [rect_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]                     m_tuser_reg;
    logic                           m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (beat_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_load) begin
            m_tdata_reg <= beat_data;
            m_tuser_reg <= beat_kind;
            m_tlast_reg <= beat_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* rtl/rect_checker.sv */
// Port-level checks of the tracker, bound to the top level.
// Depends on rect_pkg and rotary_encoder_calibration_tracker_unit_assert.svh.
`timescale 1ns / 1ps
`include "rotary_encoder_calibration_tracker_unit_assert.svh"

module rect_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rect_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                     m_tuser,
    input logic                           m_tlast
);

    `RECT_ASSERT_IMP(a_kind_legal, m_tvalid, m_tuser == rect_pkg::EV_POINT || m_tuser == rect_pkg::EV_START || m_tuser == rect_pkg::EV_DONE, "result kind out of range")

    `RECT_ASSERT_IMP(a_button_beat_last, m_tvalid && m_tuser != rect_pkg::EV_POINT, m_tlast, "start or done beat not marked last")

    `RECT_ASSERT_IMP(a_no_accept_mid_pair, m_tvalid && !m_tlast, !s_tready, "sample taken while a pair is half delivered")

    `RECT_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second sample taken straight after accept")

    `RECT_ASSERT_NXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")

endmodule

bind rotary_encoder_calibration_tracker_unit rect_checker u_rect_checker (.*);
